### rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms clocked by clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle.
`define ESC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication after a fixed number of cycles.
`define ESC_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`endif

### rtl/esc_pkg.sv
// ============================================================================
// Environmental sensor compensation package
// Item types, coefficient bundle, register indexes and shared helpers.
// ============================================================================
package esc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STAGES  = 64;
    localparam int ESC_LATENCY = 82;

    typedef enum logic [2:0] {
        ESC_REG_TEMP       = 3'd0,
        ESC_REG_PRESS_LOW  = 3'd1,
        ESC_REG_PRESS_MID  = 3'd2,
        ESC_REG_PRESS_HIGH = 3'd3,
        ESC_REG_HUM_LOW    = 3'd4,
        ESC_REG_HUM_HIGH   = 3'd5
    } esc_reg_idx_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } esc_in_t;

    typedef struct packed {
        logic signed [31:0] temp_centidegrees;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
    } esc_out_t;

    typedef struct packed {
        logic [47:0] temp_coeffs;
        logic [47:0] press_coeffs_low;
        logic [47:0] press_coeffs_mid;
        logic [47:0] press_coeffs_high;
        logic [31:0] hum_coeffs_low;
        logic [31:0] hum_coeffs_high;
    } esc_coeffs_t;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
        logic [31:0] tfine;
    } esc_work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } esc_queue_status_t;

    function automatic logic [31:0] sra32(input logic [31:0] x, input logic [5:0] sh);
        return 32'($signed(x) >>> sh);
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input logic [5:0] sh);
        return 64'($signed(x) >>> sh);
    endfunction

endpackage

### rtl/esc_front.sv
// ============================================================================
// Compensation front end
// Accepts raw items and computes the fine temperature in three stages.
// ============================================================================
module esc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  esc_pkg::esc_in_t   item,
    input  logic [47:0]        temp_coeffs,
    output logic               push,
    output esc_pkg::esc_work_t work
);
    import esc_pkg::*;

    logic        s1_valid_reg;
    esc_in_t     s1_item_reg;
    logic        s2_valid_reg;
    logic [31:0] s2_var1_reg;
    logic [31:0] s2_bb_reg;
    logic [19:0] s2_rp_reg;
    logic [15:0] s2_rh_reg;
    logic        s3_valid_reg;
    esc_work_t   s3_work_reg;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] at2;
    logic [31:0] bb;
    logic [31:0] bbs;
    logic [31:0] bt3;
    logic [31:0] var2;

    always_comb
    begin
        t1   = {16'd0, temp_coeffs[15:0]};
        t2   = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
        t3   = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
        a    = {15'd0, s1_item_reg.raw_temperature[19:3]} - {t1[30:0], 1'b0};
        b    = {16'd0, s1_item_reg.raw_temperature[19:4]} - t1;
        at2  = a * t2;
        bb   = b * b;
        bbs  = sra32(s2_bb_reg, 6'd12);
        bt3  = bbs * t3;
        var2 = sra32(bt3, 6'd14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        s2_var1_reg              <= sra32(at2, 6'd11);
        s2_bb_reg                <= bb;
        s2_rp_reg                <= s1_item_reg.raw_pressure;
        s2_rh_reg                <= s1_item_reg.raw_humidity;
        s3_work_reg.raw_pressure <= s2_rp_reg;
        s3_work_reg.raw_humidity <= s2_rh_reg;
        s3_work_reg.tfine        <= s2_var1_reg + var2;
    end

    assign push = s3_valid_reg;
    assign work = s3_work_reg;

endmodule

### rtl/esc_queue.sv
// ============================================================================
// Work queue
// Short first-in first-out buffer between the front end and the back end.
// ============================================================================
`include "assert_macros.svh"

module esc_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  esc_pkg::esc_work_t         push_data,
    input  logic                       pop,
    output esc_pkg::esc_work_t         pop_data,
    output esc_pkg::esc_queue_status_t status
);
    import esc_pkg::*;

    esc_work_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    `ESC_ASSERT_IMPL(a_no_overflow, push, !status.full)
    `ESC_ASSERT_IMPL(a_no_underflow, pop, !status.empty)

endmodule

### rtl/esc_back.sv
// ============================================================================
// Compensation back end
// Pressure and humidity pipelines with a pipelined 64-bit divider.
// ============================================================================
module esc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  esc_pkg::esc_work_t   in_data,
    input  esc_pkg::esc_coeffs_t coeffs,
    output logic                 done,
    output esc_pkg::esc_out_t    result
);
    import esc_pkg::*;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
    } side_t;

    // Coefficients
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [31:0] h4;
    logic [31:0] h5;
    logic [31:0] h6;

    // Stage valids
    logic [6:0]            b_valid_reg;
    logic [DIV_STAGES:0]   d_valid_reg;
    logic [5:0]            p_valid_reg;

    // Temperature carried through the front stages
    logic [31:0] b_temp_reg [7];

    // Stage 1
    logic [32:0] b1_w1_reg;
    logic [31:0] b1_v_reg;
    logic [19:0] b1_rp_reg;
    logic [15:0] b1_rh_reg;
    // Stage 2
    logic [63:0] b2_ww_reg;
    logic [63:0] b2_w1p5_reg;
    logic [63:0] b2_w1p2_reg;
    logic [19:0] b2_rp_reg;
    logic [15:0] b2_rh_reg;
    logic [31:0] b2_h5v_reg;
    logic [31:0] b2_vh6_reg;
    logic [31:0] b2_vh3_reg;
    // Stage 3
    logic [63:0] b3_w2a_reg;
    logic [63:0] b3_w1a_reg;
    logic [63:0] b3_w1p5_reg;
    logic [63:0] b3_w1p2_reg;
    logic [19:0] b3_rp_reg;
    logic [31:0] b3_x_reg;
    logic [31:0] b3_ya_reg;
    logic [31:0] b3_yb_reg;
    // Stage 4
    logic [63:0] b4_w2_reg;
    logic [63:0] b4_w1b_reg;
    logic [19:0] b4_rp_reg;
    logic [31:0] b4_x_reg;
    logic [31:0] b4_y0_reg;
    // Stage 5
    logic [63:0] b5_prod_reg;
    logic [63:0] b5_pnum_reg;
    logic [31:0] b5_x_reg;
    logic [31:0] b5_y_reg;
    // Stage 6
    logic [63:0] b6_div_reg;
    logic [63:0] b6_dvd_reg;
    logic [31:0] b6_v2_reg;
    // Stage 7
    logic [63:0] b7_ua_reg;
    logic [63:0] b7_ub_reg;
    logic        b7_neg_reg;
    logic        b7_zero_reg;
    logic [31:0] b7_v2_reg;
    logic [31:0] b7_ss_reg;

    // Divider stages
    logic [63:0] d_rem_reg  [DIV_STAGES+1];
    logic [63:0] d_num_reg  [DIV_STAGES+1];
    logic [63:0] d_ub_reg   [DIV_STAGES+1];
    logic        d_neg_reg  [DIV_STAGES+1];
    logic        d_zero_reg [DIV_STAGES+1];
    side_t       d_side_reg [DIV_STAGES+1];

    // Tail stages
    side_t       p_side_reg [6];
    logic        p_zero_reg [5];
    logic [63:0] q_p_reg;
    logic [63:0] p1_p_reg;
    logic [63:0] p1_qs_reg;
    logic [63:0] p2_p_reg;
    logic [63:0] p2_ll_reg;
    logic [31:0] p2_lh_reg;
    logic [63:0] p2_p8p_reg;
    logic [63:0] p3_p_reg;
    logic [63:0] p3_qq_reg;
    logic [63:0] p3_p8p_reg;
    logic [63:0] p4_p_reg;
    logic [63:0] p4_w1_reg;
    logic [63:0] p4_w2_reg;
    esc_out_t    result_reg;

    // Combinational terms
    logic [31:0]        tf5;
    logic [31:0]        b1_temp;
    logic signed [65:0] ww_full;
    logic signed [48:0] w1p5_full;
    logic signed [48:0] w1p2_full;
    logic signed [79:0] w2a_full;
    logic signed [79:0] w1a_full;
    logic [31:0]        x_sum;
    logic [31:0]        yab;
    logic [79:0]        prod_full;
    logic [20:0]        pdiff;
    logic [63:0]        pshift;
    logic [75:0]        dvd_full;
    logic [31:0]        y_sum;
    logic [31:0]        s;
    logic [31:0]        ss_s7h1;
    logic [31:0]        vv;
    logic [16:0]        hum_final;
    logic signed [79:0] p8p_full;
    logic signed [79:0] p9qq_full;
    logic [63:0]        psum;
    logic [63:0]        press64;

    always_comb
    begin
        p1 = coeffs.press_coeffs_low[15:0];
        p2 = coeffs.press_coeffs_low[31:16];
        p3 = coeffs.press_coeffs_low[47:32];
        p4 = coeffs.press_coeffs_mid[15:0];
        p5 = coeffs.press_coeffs_mid[31:16];
        p6 = coeffs.press_coeffs_mid[47:32];
        p7 = coeffs.press_coeffs_high[15:0];
        p8 = coeffs.press_coeffs_high[31:16];
        p9 = coeffs.press_coeffs_high[47:32];
        h1 = {24'd0, coeffs.hum_coeffs_low[7:0]};
        h2 = {{16{coeffs.hum_coeffs_low[23]}}, coeffs.hum_coeffs_low[23:8]};
        h3 = {24'd0, coeffs.hum_coeffs_low[31:24]};
        h4 = {{20{coeffs.hum_coeffs_high[11]}}, coeffs.hum_coeffs_high[11:0]};
        h5 = {{20{coeffs.hum_coeffs_high[23]}}, coeffs.hum_coeffs_high[23:12]};
        h6 = {{24{coeffs.hum_coeffs_high[31]}}, coeffs.hum_coeffs_high[31:24]};
    end

    always_comb
    begin
        tf5       = in_data.tfine + {in_data.tfine[29:0], 2'b00} + 32'd128;
        b1_temp   = sra32(tf5, 6'd8);
        ww_full   = $signed(b1_w1_reg) * $signed(b1_w1_reg);
        w1p5_full = $signed(b1_w1_reg) * $signed(p5);
        w1p2_full = $signed(b1_w1_reg) * $signed(p2);
        w2a_full  = $signed(b2_ww_reg) * $signed(p6);
        w1a_full  = $signed(b2_ww_reg) * $signed(p3);
        x_sum     = {b2_rh_reg, 14'd0} - {h4[11:0], 20'd0} - b2_h5v_reg + 32'd16384;
        yab       = b3_ya_reg * b3_yb_reg;
        prod_full = (b4_w1b_reg + 64'h0000_8000_0000_0000) * p1;
        pdiff     = 21'h10_0000 - {1'b0, b4_rp_reg};
        pshift    = {12'd0, pdiff, 31'd0};
        y_sum     = b4_y0_reg * h2 + 32'd8192;
        dvd_full  = b5_pnum_reg * 12'd3125;
        s         = sra32(b6_v2_reg, 6'd15);
        ss_s7h1   = sra32(sra32(b7_ss_reg, 6'd7) * h1, 6'd4);
        vv        = b7_v2_reg - ss_s7h1;
        if (vv[31])
        begin
            hum_final = '0;
        end
        else if (vv > 32'd419430400)
        begin
            hum_final = 17'd102400;
        end
        else
        begin
            hum_final = vv[28:12];
        end
        p8p_full  = $signed(p1_p_reg) * $signed(p8);
        p9qq_full = $signed(p3_qq_reg) * $signed(p9);
        psum      = p4_p_reg + p4_w1_reg + p4_w2_reg;
        press64   = sra64(psum, 6'd8) + {{44{p7[15]}}, p7, 4'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= '0;
            d_valid_reg <= '0;
            p_valid_reg <= '0;
        end
        else
        begin
            b_valid_reg <= {b_valid_reg[5:0], in_valid};
            d_valid_reg <= {d_valid_reg[DIV_STAGES-1:0], b_valid_reg[6]};
            p_valid_reg <= {p_valid_reg[4:0], d_valid_reg[DIV_STAGES]};
        end
    end

    always_ff @(posedge clk)
    begin
        b_temp_reg[0] <= b1_temp;
        for (int i = 1; i < 7; i++)
        begin
            b_temp_reg[i] <= b_temp_reg[i-1];
        end

        b1_w1_reg <= {in_data.tfine[31], in_data.tfine} - 33'd128000;
        b1_v_reg  <= in_data.tfine - 32'd76800;
        b1_rp_reg <= in_data.raw_pressure;
        b1_rh_reg <= in_data.raw_humidity;

        b2_ww_reg   <= ww_full[63:0];
        b2_w1p5_reg <= {{15{w1p5_full[48]}}, w1p5_full};
        b2_w1p2_reg <= {{15{w1p2_full[48]}}, w1p2_full};
        b2_rp_reg   <= b1_rp_reg;
        b2_rh_reg   <= b1_rh_reg;
        b2_h5v_reg  <= h5 * b1_v_reg;
        b2_vh6_reg  <= b1_v_reg * h6;
        b2_vh3_reg  <= b1_v_reg * h3;

        b3_w2a_reg  <= w2a_full[63:0];
        b3_w1a_reg  <= w1a_full[63:0];
        b3_w1p5_reg <= b2_w1p5_reg;
        b3_w1p2_reg <= b2_w1p2_reg;
        b3_rp_reg   <= b2_rp_reg;
        b3_x_reg    <= sra32(x_sum, 6'd15);
        b3_ya_reg   <= sra32(b2_vh6_reg, 6'd10);
        b3_yb_reg   <= sra32(b2_vh3_reg, 6'd11) + 32'd32768;

        b4_w2_reg  <= b3_w2a_reg + {b3_w1p5_reg[46:0], 17'd0}
                      + {{13{p4[15]}}, p4, 35'd0};
        b4_w1b_reg <= sra64(b3_w1a_reg, 6'd8) + {b3_w1p2_reg[51:0], 12'd0};
        b4_rp_reg  <= b3_rp_reg;
        b4_x_reg   <= b3_x_reg;
        b4_y0_reg  <= sra32(yab, 6'd10) + 32'd2097152;

        b5_prod_reg <= prod_full[63:0];
        b5_pnum_reg <= pshift - b4_w2_reg;
        b5_x_reg    <= b4_x_reg;
        b5_y_reg    <= sra32(y_sum, 6'd14);

        b6_div_reg <= sra64(b5_prod_reg, 6'd33);
        b6_dvd_reg <= dvd_full[63:0];
        b6_v2_reg  <= b5_x_reg * b5_y_reg;

        b7_ua_reg   <= b6_dvd_reg[63] ? (64'd0 - b6_dvd_reg) : b6_dvd_reg;
        b7_ub_reg   <= b6_div_reg[63] ? (64'd0 - b6_div_reg) : b6_div_reg;
        b7_neg_reg  <= b6_dvd_reg[63] ^ b6_div_reg[63];
        b7_zero_reg <= (b6_div_reg == '0);
        b7_v2_reg   <= b6_v2_reg;
        b7_ss_reg   <= s * s;

        d_rem_reg[0]       <= '0;
        d_num_reg[0]       <= b7_ua_reg;
        d_ub_reg[0]        <= b7_ub_reg;
        d_neg_reg[0]       <= b7_neg_reg;
        d_zero_reg[0]      <= b7_zero_reg;
        d_side_reg[0].temp <= b_temp_reg[6];
        d_side_reg[0].hum  <= hum_final;
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [64:0] trial;
        logic [64:0] diff;
        logic        ge;

        assign trial = {d_rem_reg[k], d_num_reg[k][63]};
        assign diff  = trial - {1'b0, d_ub_reg[k]};
        assign ge    = (trial >= {1'b0, d_ub_reg[k]});

        always_ff @(posedge clk)
        begin
            d_rem_reg[k+1]  <= ge ? diff[63:0] : trial[63:0];
            d_num_reg[k+1]  <= {d_num_reg[k][62:0], ge};
            d_ub_reg[k+1]   <= d_ub_reg[k];
            d_neg_reg[k+1]  <= d_neg_reg[k];
            d_zero_reg[k+1] <= d_zero_reg[k];
            d_side_reg[k+1] <= d_side_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        q_p_reg <= d_neg_reg[DIV_STAGES] ? (64'd0 - d_num_reg[DIV_STAGES])
                                         : d_num_reg[DIV_STAGES];
        p_side_reg[0] <= d_side_reg[DIV_STAGES];
        p_zero_reg[0] <= d_zero_reg[DIV_STAGES];
        for (int i = 1; i < 5; i++)
        begin
            p_side_reg[i] <= p_side_reg[i-1];
            p_zero_reg[i] <= p_zero_reg[i-1];
        end
        p_side_reg[5] <= p_side_reg[4];

        p1_p_reg  <= q_p_reg;
        p1_qs_reg <= sra64(q_p_reg, 6'd13);

        p2_p_reg   <= p1_p_reg;
        p2_ll_reg  <= p1_qs_reg[31:0] * p1_qs_reg[31:0];
        p2_lh_reg  <= p1_qs_reg[31:0] * p1_qs_reg[63:32];
        p2_p8p_reg <= p8p_full[63:0];

        p3_p_reg   <= p2_p_reg;
        p3_qq_reg  <= p2_ll_reg + {p2_lh_reg[30:0], 33'd0};
        p3_p8p_reg <= p2_p8p_reg;

        p4_p_reg  <= p3_p_reg;
        p4_w1_reg <= sra64(p9qq_full[63:0], 6'd25);
        p4_w2_reg <= sra64(p3_p8p_reg, 6'd19);

        result_reg.temp_centidegrees <= p_side_reg[4].temp;
        result_reg.humidity_q22_10   <= p_side_reg[4].hum;
        result_reg.pressure_q24_8    <= p_zero_reg[4] ? 32'd0 : press64[31:0];
    end

    assign done   = p_valid_reg[5];
    assign result = result_reg;

endmodule

### rtl/environmental_sensor_compensation.sv
// ============================================================================
// Environmental sensor compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// An accepted item flows through the front end, queue and back end to done.
// Throughput: one item per cycle while not busy, set by the fully pipelined
// 64-stage pressure divider. Reset clears all pipeline valids, the queue and
// the coefficient registers; results are never held off by the receiver.
// ============================================================================
`include "assert_macros.svh"

module environmental_sensor_compensation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  esc_pkg::esc_in_t  item,
    output logic              done,
    output esc_pkg::esc_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [47:0]       cfg_data
);
    import esc_pkg::*;

    esc_coeffs_t       coeffs_reg;
    esc_queue_status_t q_status;
    esc_work_t         push_data;
    esc_work_t         pop_data;
    logic              push;
    logic              pop;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign busy      = q_status.full;
    assign accept    = start && !busy;
    assign pop       = !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ESC_REG_TEMP:       coeffs_reg.temp_coeffs       <= cfg_data;
                ESC_REG_PRESS_LOW:  coeffs_reg.press_coeffs_low  <= cfg_data;
                ESC_REG_PRESS_MID:  coeffs_reg.press_coeffs_mid  <= cfg_data;
                ESC_REG_PRESS_HIGH: coeffs_reg.press_coeffs_high <= cfg_data;
                ESC_REG_HUM_LOW:    coeffs_reg.hum_coeffs_low    <= cfg_data[31:0];
                ESC_REG_HUM_HIGH:   coeffs_reg.hum_coeffs_high   <= cfg_data[31:0];
                default:            coeffs_reg                   <= coeffs_reg;
            endcase
        end
    end

    esc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .temp_coeffs (coeffs_reg.temp_coeffs),
        .push        (push),
        .work        (push_data)
    );

    esc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    esc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop),
        .in_data  (pop_data),
        .coeffs   (coeffs_reg),
        .done     (done),
        .result   (result)
    );

    `ESC_ASSERT_DELAY(a_fixed_latency, accept, ESC_LATENCY, done)

endmodule

### bench/environmental_sensor_compensation_tb.sv
// ----------------------------------------------------------------------------
// Environmental sensor compensation testbench
// Drives raw readings under several coefficient settings, predicts each
// compensated temperature, pressure and humidity, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module environmental_sensor_compensation_tb;
    import esc_pkg::*;

    localparam logic [2:0] REG_UNUSED_A = 3'd6;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = ESC_LATENCY + 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    esc_in_t item = '0;
    logic done;
    esc_out_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;

    logic [47:0] coeff_regs [0:5];
    esc_out_t expected_q [$];
    int mismatches = 0;
    int idle_pct = 0;
    int quiet_cycles = 0;

    environmental_sensor_compensation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] f);
        return {{48{f[15]}}, f};
    endfunction

    function automatic logic [63:0] quot64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic esc_out_t compensate(input esc_in_t r);
        esc_out_t o;
        logic [31:0] t1, t2, t3, a, b, bb, var1, var2, tfine, tmp;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] w1, w2, p, q, num, tf;
        logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, y1, y2, s, rh;
        logic [47:0] tc, pl, pm, ph;
        logic [31:0] hl, hh;
        tc = coeff_regs[0]; pl = coeff_regs[1]; pm = coeff_regs[2];
        ph = coeff_regs[3]; hl = coeff_regs[4][31:0]; hh = coeff_regs[5][31:0];

        t1 = {16'd0, tc[15:0]};
        t2 = {{16{tc[31]}}, tc[31:16]};
        t3 = {{16{tc[47]}}, tc[47:32]};
        a = {12'd0, r.raw_temperature} >> 3;
        a = a - (t1 << 1);
        tmp = a * t2;
        var1 = asr32(tmp, 11);
        b = ({12'd0, r.raw_temperature} >> 4) - t1;
        bb = b * b;
        tmp = asr32(bb, 12) * t3;
        var2 = asr32(tmp, 14);
        tfine = var1 + var2;
        tmp = tfine * 32'd5 + 32'd128;
        o.temp_centidegrees = asr32(tmp, 8);

        p1 = {48'd0, pl[15:0]};
        p2 = sx16(pl[31:16]); p3 = sx16(pl[47:32]);
        p4 = sx16(pm[15:0]); p5 = sx16(pm[31:16]); p6 = sx16(pm[47:32]);
        p7 = sx16(ph[15:0]); p8 = sx16(ph[31:16]); p9 = sx16(ph[47:32]);
        tf = {{32{tfine[31]}}, tfine};
        w1 = tf - 64'd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) << 17);
        w2 = w2 + (p4 << 35);
        w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = asr64((64'h0000_8000_0000_0000 + w1) * p1, 33);
        o.pressure_q24_8 = '0;
        if (w1 != 64'd0)
        begin
            p = 64'd1048576 - {44'd0, r.raw_pressure};
            num = ((p << 31) - w2) * 64'd3125;
            p = quot64(num, w1);
            q = asr64(p, 13);
            w1 = asr64(p9 * q * q, 25);
            w2 = asr64(p8 * p, 19);
            p = asr64(p + w1 + w2, 8) + (p7 << 4);
            o.pressure_q24_8 = p[31:0];
        end

        h1 = {24'd0, hl[7:0]};
        h2 = {{16{hl[23]}}, hl[23:8]};
        h3 = {24'd0, hl[31:24]};
        h4 = {{20{hh[11]}}, hh[11:0]};
        h5 = {{20{hh[23]}}, hh[23:12]};
        h6 = {{24{hh[31]}}, hh[31:24]};
        rh = {16'd0, r.raw_humidity};
        v = tfine - 32'd76800;
        tmp = (rh << 14) - (h4 << 20) - h5 * v + 32'd16384;
        x = asr32(tmp, 15);
        y1 = asr32(v * h6, 10);
        y2 = asr32(v * h3, 11) + 32'd32768;
        tmp = y1 * y2;
        y = asr32(tmp, 10) + 32'd2097152;
        tmp = y * h2 + 32'd8192;
        y = asr32(tmp, 14);
        v = x * y;
        s = asr32(v, 15);
        tmp = asr32(s * s, 7) * h1;
        v = v - asr32(tmp, 4);
        if (v[31])
            v = 32'd0;
        else if (v > 32'd419430400)
            v = 32'd419430400;
        o.humidity_q22_10 = v[28:12];
        return o;
    endfunction

    always @(posedge clk)
    begin
        esc_out_t exp_r;
        if (rst_n && start && !busy)
            expected_q.push_back(compensate(item));
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (exp_r.temp_centidegrees !== result.temp_centidegrees ||
                    exp_r.pressure_q24_8 !== result.pressure_q24_8 ||
                    exp_r.humidity_q22_10 !== result.humidity_q22_10)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected T=%0d P=%0d H=%0d, got T=%0d P=%0d H=%0d",
                                 exp_r.temp_centidegrees, exp_r.pressure_q24_8,
                                 exp_r.humidity_q22_10, result.temp_centidegrees,
                                 result.pressure_q24_8, result.humidity_q22_10);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_reading(input esc_in_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx <= ESC_REG_HUM_HIGH)
            coeff_regs[idx] = (idx >= ESC_REG_HUM_LOW) ? {16'd0, data[31:0]} : data;
    endtask

    task automatic load_coeffs(input logic [47:0] t, input logic [47:0] pl,
                               input logic [47:0] pm, input logic [47:0] ph,
                               input logic [47:0] hl, input logic [47:0] hh);
        write_reg(ESC_REG_TEMP, t);
        write_reg(ESC_REG_PRESS_LOW, pl);
        write_reg(ESC_REG_PRESS_MID, pm);
        write_reg(ESC_REG_PRESS_HIGH, ph);
        write_reg(ESC_REG_HUM_LOW, hl);
        write_reg(ESC_REG_HUM_HIGH, hh);
        @(posedge clk);
    endtask

    task automatic load_typical();
        load_coeffs({-16'sd1000, 16'sd26435, 16'd27504},
                    {16'sd3024, -16'sd10685, 16'd36477},
                    {-16'sd7, 16'sd140, 16'sd2855},
                    {16'sd6000, -16'sd14600, 16'sd15500},
                    {16'd0, 8'd0, 16'sd362, 8'd75},
                    {16'd0, 8'sd30, 12'sd50, 12'sd313});
    endtask

    function automatic esc_in_t rand_reading();
        esc_in_t r;
        r.raw_temperature = 20'($urandom);
        r.raw_pressure = 20'($urandom);
        r.raw_humidity = 16'($urandom);
        if ($urandom_range(3) != 0)
        begin
            r.raw_temperature = 20'($urandom_range(560000, 440000));
            r.raw_pressure = 20'($urandom_range(460000, 300000));
            r.raw_humidity = 16'($urandom_range(36000, 20000));
        end
        return r;
    endfunction

    function automatic logic [47:0] nudge(input logic [47:0] base);
        logic [47:0] n;
        n = base;
        n[15:0] = n[15:0] + 16'($urandom_range(64)) - 16'd32;
        n[31:16] = n[31:16] + 16'($urandom_range(64)) - 16'd32;
        n[47:32] = n[47:32] + 16'($urandom_range(8)) - 16'd4;
        return n;
    endfunction

    task automatic test_reset_defaults();
        send_reading('{20'd0, 20'd0, 16'd0});
        send_reading('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_reading('{20'd519888, 20'd415148, 16'd30000});
        end_burst();
    endtask

    task automatic test_directed();
        load_typical();
        send_reading('{20'd519888, 20'd415148, 16'd30000});
        send_reading('{20'd0, 20'd0, 16'd0});
        send_reading('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_reading('{20'd0, 20'hFFFFF, 16'hFFFF});
        send_reading('{20'hFFFFF, 20'd0, 16'd0});
        send_reading('{20'd440064, 20'd1, 16'h8000});
        end_burst();
        // A zero low pressure register makes the pressure divisor zero.
        write_reg(ESC_REG_PRESS_LOW, 48'd0);
        send_reading('{20'd519888, 20'd415148, 16'd30000});
        end_burst();
        write_reg(REG_UNUSED_A, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_UNUSED_B, 48'h1234_5678_9ABC);
        send_reading('{20'd519888, 20'd415148, 16'd30000});
        end_burst();
        load_coeffs({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                    {48{1'b1}}, {48{1'b1}});
        send_reading('{20'd0, 20'd0, 16'd0});
        send_reading('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_reading('{20'd524288, 20'd524288, 16'h8000});
        end_burst();
        load_coeffs({1'b0, {47{1'b1}}}, {1'b1, 15'd0, 1'b1, 15'd0, 16'hFFFF},
                    {1'b1, 15'd0, 1'b1, 15'd0, 1'b1, 15'd0},
                    {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'd0, 8'hFF, 16'h7FFF, 8'hFF},
                    {16'd0, 8'h7F, 12'h7FF, 12'h800});
        send_reading('{20'hFFFFF, 20'd0, 16'hFFFF});
        send_reading('{20'd0, 20'hFFFFF, 16'd0});
        send_reading('{20'd500000, 20'd400000, 16'd25000});
        end_burst();
    endtask

    task automatic test_random_phase(input int pct, input int settings);
        idle_pct = pct;
        for (int s = 0; s < settings; s++)
        begin
            if (s % 3 == 2)
                load_coeffs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                            48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                            48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            else
                load_coeffs(nudge({-16'sd1000, 16'sd26435, 16'd27504}),
                            nudge({16'sd3024, -16'sd10685, 16'd36477}),
                            nudge({-16'sd7, 16'sd140, 16'sd2855}),
                            nudge({16'sd6000, -16'sd14600, 16'sd15500}),
                            {16'($urandom), 8'($urandom_range(255)),
                             16'($urandom_range(600)), 8'($urandom_range(255))},
                            {16'($urandom), 8'($urandom_range(60)), 12'($urandom_range(100)),
                             12'($urandom_range(500))});
            repeat (150) send_reading(rand_reading());
            end_burst();
        end
    endtask

    initial
    begin
        for (int i = 0; i < 6; i++)
            coeff_regs[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random_phase(18, 3);
        test_random_phase(72, 3);
        test_random_phase(0, 3);
        end_burst();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_front.sv
rtl/esc_queue.sv
rtl/esc_back.sv
rtl/environmental_sensor_compensation.sv
bench/environmental_sensor_compensation_tb.sv
